FILE: rtl/swmm_pkg.sv
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared widths and constants of the sliding-window mean and median unit.
// ----------------------------------------------------------------------------
package swmm_pkg;

  // Width of one distance sample and of each result field
  localparam int SAMPLE_W = 16;

  // Width of the running window sum (holds 32 * 65535)
  localparam int SUM_W = 22;

  // Default window depth and its allowed upper limit
  localparam int WINDOW_SIZE_DEF = 8;
  localparam int WINDOW_SIZE_MAX = 32;

  // Fraction bits of the reciprocal used for the mean; exact for every sum
  // below 2^21 and every window depth up to the limit
  localparam int RECIP_SHIFT = 27;

  // One distance sample or one result field
  typedef logic [SAMPLE_W-1:0] sample_t;

endpackage

FILE: rtl/swmm_window.sv
// ----------------------------------------------------------------------------
// swmm_window
// Shift-register window of the most recent samples with a running sum.
// ----------------------------------------------------------------------------
module swmm_window #(
  parameter int WINDOW_SIZE = swmm_pkg::WINDOW_SIZE_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        shift_i,
  input  swmm_pkg::sample_t                           sample_i,
  output logic [WINDOW_SIZE-1:0][swmm_pkg::SAMPLE_W-1:0] window_o,
  output logic [swmm_pkg::SUM_W-1:0]                  sum_o
);
  import swmm_pkg::*;

  logic [WINDOW_SIZE-1:0][SAMPLE_W-1:0] window_q, window_d;
  logic [SUM_W-1:0]                     sum_q, sum_d;

  // Drop the oldest sample, append the newest, and track the sum
  always_comb begin
    window_d = window_q;
    sum_d    = sum_q;
    if (shift_i) begin
      for (int i = 0; i < WINDOW_SIZE - 1; i++) begin
        window_d[i] = window_q[i+1];
      end
      window_d[WINDOW_SIZE-1] = sample_i;
      sum_d = sum_q + SUM_W'(sample_i) - SUM_W'(window_q[0]);
    end
  end

  // Hold the window and sum; reset clears both to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      sum_q    <= '0;
    end else begin
      window_q <= window_d;
      sum_q    <= sum_d;
    end
  end

  assign window_o = window_q;
  assign sum_o    = sum_q;

endmodule

FILE: rtl/swmm_mean.sv
// ----------------------------------------------------------------------------
// swmm_mean
// Truncated mean of the window: sum times a fixed-point reciprocal.
// ----------------------------------------------------------------------------
module swmm_mean #(
  parameter int WINDOW_SIZE = swmm_pkg::WINDOW_SIZE_DEF
) (
  input  logic [swmm_pkg::SUM_W-1:0] sum_i,
  output swmm_pkg::sample_t          mean_o
);
  import swmm_pkg::*;

  // Rounded-up reciprocal; its error times the largest sum stays below one ulp
  localparam int  RECIP_W = RECIP_SHIFT + 1;
  localparam int  RECIP   = ((1 << RECIP_SHIFT) + WINDOW_SIZE - 1) / WINDOW_SIZE;
  localparam int  PROD_W  = SUM_W + RECIP_W;

  logic [PROD_W-1:0] product;

  // Scale the sum and keep the integer part
  assign product = PROD_W'(sum_i) * PROD_W'(RECIP_W'(RECIP));
  assign mean_o  = product[RECIP_SHIFT +: SAMPLE_W];

endmodule

FILE: rtl/swmm_median.sv
// ----------------------------------------------------------------------------
// swmm_median
// Parallel rank compare over the window; picks the element of middle rank.
// ----------------------------------------------------------------------------
module swmm_median #(
  parameter int WINDOW_SIZE = swmm_pkg::WINDOW_SIZE_DEF
) (
  input  logic [WINDOW_SIZE-1:0][swmm_pkg::SAMPLE_W-1:0] window_i,
  output swmm_pkg::sample_t                              median_o
);
  import swmm_pkg::*;

  localparam int RANK_W = $clog2(WINDOW_SIZE + 1);
  localparam int MID    = WINDOW_SIZE / 2;

  logic [RANK_W-1:0] rank [WINDOW_SIZE];

  // Count the elements ordered ahead of each one; ties break by position
  always_comb begin
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW_SIZE; j++) begin
        if ((window_i[j] < window_i[i]) || ((window_i[j] == window_i[i]) && (j < i))) begin
          rank[i] = rank[i] + RANK_W'(1);
        end
      end
    end
  end

  // Exactly one element holds the middle rank; merge it out
  always_comb begin
    median_o = '0;
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      if (rank[i] == RANK_W'(MID)) begin
        median_o = median_o | window_i[i];
      end
    end
  end

endmodule

FILE: rtl/sliding_window_mean_median_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_mean_median_unit
// Moving average and running median over the last WINDOW_SIZE samples.
// ----------------------------------------------------------------------------
// Each accepted word carries one 16-bit distance sample. The sample is shifted
// into a window of the WINDOW_SIZE most recent samples (all zero after reset,
// and those zeros count until shifted out), and one result word follows per
// sample: the truncated mean and the median, the sorted element at index
// WINDOW_SIZE/2. The unit takes one sample every clock cycle unless stalled. The
// accepting edge shifts the window and updates the running sum; in the
// following cycle the mean comes from a reciprocal multiply and the median
// from a parallel rank compare of all window elements, and the edge at which
// the window stage advances loads the output register. The input stalls only
// while both the window stage and the output register hold words and the
// output is stalled.
module sliding_window_mean_median_unit #(
  parameter int WINDOW_SIZE = swmm_pkg::WINDOW_SIZE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [swmm_pkg::SAMPLE_W-1:0] s_axis_tdata_i,   // [15:0] sample_mm
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [2*swmm_pkg::SAMPLE_W-1:0] m_axis_tdata_o  // [15:0] mean_mm,
                                                          // [31:16] median_mm
);
  import swmm_pkg::*;

  logic                                 stage_valid_q, stage_valid_d;
  logic                                 out_valid_q, out_valid_d;
  sample_t                              mean_q, median_q;
  logic                                 out_ready;
  logic                                 accept;
  logic                                 advance;
  logic [WINDOW_SIZE-1:0][SAMPLE_W-1:0] window;
  logic [SUM_W-1:0]                     sum;
  sample_t                              mean;
  sample_t                              median;

  // Handshake: output register frees when empty or taken
  assign out_ready       = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !stage_valid_q || out_ready;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign advance         = stage_valid_q && out_ready;

  swmm_window #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (accept),
    .sample_i (s_axis_tdata_i),
    .window_o (window),
    .sum_o    (sum)
  );

  swmm_mean #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) u_mean (
    .sum_i  (sum),
    .mean_o (mean)
  );

  swmm_median #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) u_median (
    .window_i (window),
    .median_o (median)
  );

  // Track occupancy of the window stage and the output register
  always_comb begin
    stage_valid_d = stage_valid_q;
    if (accept) begin
      stage_valid_d = 1'b1;
    end else if (advance) begin
      stage_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Load the result word when the window stage advances
  always_ff @(posedge clk_i) begin
    if (advance) begin
      mean_q   <= mean;
      median_q <= median;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {median_q, mean_q};

endmodule

FILE: rtl/swmm_checker.sv
// ----------------------------------------------------------------------------
// swmm_checker
// Port-level checks of the sliding-window mean and median unit.
// ----------------------------------------------------------------------------
module swmm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic [swmm_pkg::SAMPLE_W-1:0]   s_axis_tdata_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [2*swmm_pkg::SAMPLE_W-1:0] m_axis_tdata_o
);

  // Stalled result word holds its valid and data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("result word changed while stalled");

  // Input stalls only behind a full, stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without output back-pressure");

  // An empty output means the pipeline has room
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input not ready while output register empty");

  // A new result word needs room taken at the previous edge
  a_rise_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tready_o))
    else $error("result appeared without pipeline room");

endmodule

bind sliding_window_mean_median_unit swmm_checker u_swmm_checker (.*);
